### src/lfu_pkg.sv
// Shared constants, types and state codes for the LFU cache core.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;

    // Storage geometry
    localparam int ENTRIES    = 16;
    localparam int SLOTS      = ENTRIES + 1;          // one spare slot for the appended entry
    localparam int SLOT_AW    = $clog2(SLOTS);        // index into the slot arrays
    localparam int CNT_W      = $clog2(SLOTS + 1);    // holds a fill count up to SLOTS

    // Field widths
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 32;
    localparam int USE_BITS   = 32;
    localparam int OCC_W      = 5;
    localparam int LIMIT_W    = 5;

    localparam logic [USE_BITS-1:0] USE_MAX    = '1;
    localparam logic [LIMIT_W-1:0]  LIMIT_INIT = LIMIT_W'(16);

    // Command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LOOKUP,
        ST_APPEND,
        ST_CHECK,
        ST_MIN_SCAN,
        ST_SHIFT,
        ST_FINISH
    } lfu_state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;      // capture the accepted item, clear result
        logic look_step;  // advance the lookup index
        logic look_hit;   // record hit, bump the use count
        logic append;     // write the new entry at the fill count
        logic min_clear;  // start the minimum scan at entry 0
        logic min_step;   // compare one count against the running minimum
        logic shift;      // drop the minimum entry, close the gap
        logic out_load;   // move the result into the output register
    } lfu_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_insert;
        logic scan_end;
        logic key_eq;
        logic over;
        logic out_free;
    } lfu_sts_t;

endpackage
`default_nettype wire

### src/lfu_if.sv
// Handshake channel interfaces for request, response and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface lfu_req_if
    import lfu_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value_in;

    modport source (output valid, output command, output key, output value_in, input ready);
    modport sink   (input valid, input command, input key, input value_in, output ready);
endinterface

interface lfu_rsp_if
    import lfu_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [VALUE_BITS-1:0] value_out;
    logic [OCC_W-1:0]      occupancy;
    logic [OCC_W-1:0]      evictions;

    modport source (output valid, output hit, output value_out, output occupancy,
                    output evictions, input ready);
    modport sink   (input valid, input hit, input value_out, input occupancy,
                    input evictions, output ready);
endinterface

interface lfu_cfg_if
    import lfu_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/lfu_ctrl.sv
// Sequencer for lookup scan, append, minimum scan and compaction.
`timescale 1ns / 1ps
`default_nettype none
module lfu_ctrl
    import lfu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire lfu_sts_t sts,
    output lfu_cmd_t      cmd,
    output lfu_state_t    state
);

    lfu_state_t state_reg;
    lfu_state_t state_next;

    assign state = state_reg;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pick the next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = sts.is_insert ? ST_APPEND : ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (sts.scan_end || sts.key_eq)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_APPEND:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = sts.over ? ST_MIN_SCAN : ST_FINISH;
            end
            ST_MIN_SCAN:
            begin
                if (sts.scan_end)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            ST_LOOKUP:
            begin
                if (!sts.scan_end)
                begin
                    if (sts.key_eq)
                    begin
                        cmd.look_hit = 1'b1;
                    end
                    else
                    begin
                        cmd.look_step = 1'b1;
                    end
                end
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.min_clear = sts.over;
            end
            ST_MIN_SCAN:
            begin
                cmd.min_step = !sts.scan_end;
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

### src/lfu_dp.sv
// Entry storage, scan index, minimum tracker and result register.
`timescale 1ns / 1ps
`default_nettype none
module lfu_dp
    import lfu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    lfu_req_if.sink       req,
    lfu_rsp_if.source     rsp,
    lfu_cfg_if.sink       cfg,
    input  wire lfu_cmd_t cmd,
    output lfu_sts_t      sts
);

    // Entry storage in insertion order, oldest at slot 0
    logic [KEY_BITS-1:0]   keys_reg [SLOTS];
    logic [VALUE_BITS-1:0] vals_reg [SLOTS];
    logic [USE_BITS-1:0]   uses_reg [SLOTS];

    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [SLOT_AW-1:0]    min_idx_reg;
    logic [USE_BITS-1:0]   min_use_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    logic                  cmd_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] vout_reg;
    logic [OCC_W-1:0]      evict_reg;

    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic [OCC_W-1:0]      out_occ_reg;
    logic [OCC_W-1:0]      out_evict_reg;

    logic [SLOT_AW-1:0]    rd_idx;
    logic [SLOT_AW-1:0]    wr_idx;
    logic [USE_BITS-1:0]   rd_use;
    logic [CNT_W-1:0]      lim_eff;

    assign rd_idx = idx_reg[SLOT_AW-1:0];
    assign wr_idx = fill_reg[SLOT_AW-1:0];
    assign rd_use = uses_reg[rd_idx];

    // Cap the limit at the storage size
    assign lim_eff = (int'(limit_reg) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(limit_reg);

    // Report status to the sequencer
    always_comb
    begin
        sts.is_insert = (cmd_reg == CMD_INSERT);
        sts.scan_end  = (idx_reg >= fill_reg);
        sts.key_eq    = (keys_reg[rd_idx] == key_reg);
        sts.over      = (fill_reg > lim_eff);
        sts.out_free  = !out_valid_reg || rsp.ready;
    end

    assign cfg.ready = 1'b1;
    assign req.ready = cmd.latch;

    // Hold the capacity limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_INIT;
        end
        else if (cfg.valid)
        begin
            limit_reg <= cfg.data;
        end
    end

    // Advance control counters and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            evict_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                idx_reg   <= '0;
                hit_reg   <= 1'b0;
                evict_reg <= '0;
            end
            if (cmd.look_step || cmd.min_step)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.look_hit)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.append)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            if (cmd.min_clear)
            begin
                idx_reg <= CNT_W'(1);
            end
            if (cmd.shift)
            begin
                fill_reg  <= fill_reg - CNT_W'(1);
                evict_reg <= evict_reg + OCC_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture payload, track minimum, load result
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg  <= req.command;
            key_reg  <= req.key;
            val_reg  <= req.value_in;
            vout_reg <= '0;
        end
        if (cmd.look_hit)
        begin
            vout_reg <= vals_reg[rd_idx];
        end
        if (cmd.min_clear)
        begin
            min_idx_reg <= '0;
            min_use_reg <= uses_reg[0];
        end
        if (cmd.min_step && (rd_use < min_use_reg))
        begin
            min_idx_reg <= rd_idx;
            min_use_reg <= rd_use;
        end
        if (cmd.out_load)
        begin
            out_hit_reg   <= hit_reg;
            out_value_reg <= vout_reg;
            out_occ_reg   <= OCC_W'(fill_reg);
            out_evict_reg <= evict_reg;
        end
    end

    // Update entry storage: bump, append, close the gap
    always_ff @(posedge clk)
    begin
        if (cmd.look_hit && (rd_use != USE_MAX))
        begin
            uses_reg[rd_idx] <= rd_use + USE_BITS'(1);
        end
        if (cmd.append)
        begin
            keys_reg[wr_idx] <= key_reg;
            vals_reg[wr_idx] <= val_reg;
            uses_reg[wr_idx] <= '0;
        end
        if (cmd.shift)
        begin
            for (int i = 0; i < SLOTS - 1; i++)
            begin
                if (i >= int'(min_idx_reg))
                begin
                    keys_reg[i] <= keys_reg[i+1];
                    vals_reg[i] <= vals_reg[i+1];
                    uses_reg[i] <= uses_reg[i+1];
                end
            end
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.hit       = out_hit_reg;
    assign rsp.value_out = out_value_reg;
    assign rsp.occupancy = out_occ_reg;
    assign rsp.evictions = out_evict_reg;

endmodule
`default_nettype wire

### src/lfu_cache_lookup_insert_core.sv
// A lookup scans the entries in order until the key matches or all held ones are seen;
// an insert appends the new entry, then drops the least-used entry while over the limit.
// One item in flight; the next is taken the cycle after the result is registered, where
// the sink may hold it. Reset empties the cache (occupancy 0) and sets the capacity
// limit to 16; entry contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module lfu_cache_lookup_insert_core
    import lfu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    lfu_req_if.sink   req,
    lfu_rsp_if.source rsp,
    lfu_cfg_if.sink   cfg
);

    lfu_cmd_t   cmd;
    lfu_sts_t   sts;
    lfu_state_t state;
    logic       in_ready;

    lfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd),
        .state    (state)
    );

    lfu_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

`ifndef NO_ASSERTIONS
    // An accepted item blocks further input on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in progress");

    // Input is only taken from the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state == ST_IDLE))
        else $error("ready outside idle");

    // Occupancy reported never exceeds storage
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (int'(rsp.occupancy) <= ENTRIES))
        else $error("occupancy above storage size");

    // A hit comes only from a lookup, which evicts nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> (rsp.evictions == '0))
        else $error("hit reported with evictions");

    // A miss returns a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.hit) |-> (rsp.value_out == '0))
        else $error("nonzero value on a miss");
`endif

endmodule
`default_nettype wire
